/* rtl/core/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, constants and helpers of the world-to-screen projection unit.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int COORD_W  = 32;
    localparam int PAIR_W   = 64;
    localparam int N_PAIRS  = 8;
    localparam int FRAC_W   = 16;
    localparam int NUM_W    = COORD_W + FRAC_W;   // magnitude of clip * 65536
    localparam int DEN_W    = COORD_W;            // magnitude of w
    localparam int DIV_STEPS = NUM_W;             // one quotient bit per stage
    localparam int N_LANES  = 3;                  // x, y, z numerators
    localparam int CFG_IDX_W = 4;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    localparam logic signed [63:0] HALF_W    = 64'sd400;
    localparam logic signed [63:0] NEG_HALF_H = -64'sd300;
    localparam logic signed [63:0] SX_OFFSET = 64'sd26214400;  // 400.0 in Q16.16
    localparam logic signed [63:0] SY_OFFSET = 64'sd19660800;  // 300.0 in Q16.16

    // identity matrix, column major, two entries per word
    localparam logic [N_PAIRS-1:0][PAIR_W-1:0] M_RESET = {
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic                vis;
        logic                dz;
        logic                w_neg;
        logic [N_LANES-1:0]  n_neg;
        logic [N_LANES-1:0]  n_zero;
        logic [COORD_W-1:0]  cw;
    } wsp_side_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic [COORD_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[COORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/wsp_transform.sv */
// ----------------------------------------------------------------------------
// wsp_transform
// Matrix times (x, y, z, 1): input register, product stage, sum stage.
// ----------------------------------------------------------------------------
module wsp_transform
    import wsp_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [COORD_W-1:0]          pos_x,
    input  logic signed [COORD_W-1:0]          pos_y,
    input  logic signed [COORD_W-1:0]          pos_z,
    input  logic [N_PAIRS-1:0][PAIR_W-1:0]     m_pair,
    output logic                               out_valid,
    output logic [3:0][COORD_W-1:0]            clip
);

    logic                        v0_reg;
    logic                        v1_reg;
    logic                        v2_reg;
    logic signed [COORD_W-1:0]   coord_reg [3];
    logic signed [NUM_W-1:0]     prod_reg [3][4];
    logic signed [NUM_W-1:0]     prod_next [3][4];
    logic [3:0][COORD_W-1:0]     clip_reg;
    logic [3:0][COORD_W-1:0]     clip_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg[0] <= pos_x;
        coord_reg[1] <= pos_y;
        coord_reg[2] <= pos_z;
        prod_reg     <= prod_next;
        clip_reg     <= clip_next;
    end

    // entry (row r, col c) sits in pair 2c + r/2, upper half for odd r
    for (genvar c = 0; c < 3; c++)
    begin : g_col
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            logic signed [63:0] full;
            assign full = 64'(coord_reg[c])
                        * 64'($signed(m_pair[2*c + r/2][32*(r%2) +: COORD_W]));
            // floor to Q16.16
            assign prod_next[c][r] = full[63:FRAC_W];
        end
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_sum
        logic signed [63:0] sum;
        assign sum = 64'(prod_reg[0][r]) + 64'(prod_reg[1][r]) + 64'(prod_reg[2][r])
                   + 64'($signed(m_pair[6 + r/2][32*(r%2) +: COORD_W]));
        assign clip_next[r] = sat32(sum);
    end

    assign out_valid = v2_reg;
    assign clip      = clip_reg;

endmodule

/* rtl/core/wsp_divider.sv */
// ----------------------------------------------------------------------------
// wsp_divider
// Pipelined restoring divider: |clip| * 65536 / |w| for three lanes that
// share one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsp_divider
    import wsp_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [3:0][COORD_W-1:0]            clip,
    output logic                               out_valid,
    output logic [N_LANES-1:0][NUM_W-1:0]      quot,
    output wsp_side_t                          side
);

    logic [DIV_STEPS:0]          valid_reg;
    logic [NUM_W-1:0]            num_reg  [DIV_STEPS+1][N_LANES];
    logic [DEN_W-1:0]            rem_reg  [DIV_STEPS+1][N_LANES];
    logic [DEN_W-1:0]            den_reg  [DIV_STEPS+1];
    wsp_side_t                   side_reg [DIV_STEPS+1];
    logic [NUM_W-1:0]            num_next [DIV_STEPS+1][N_LANES];
    logic [DEN_W-1:0]            rem_next [DIV_STEPS+1][N_LANES];
    logic [DEN_W-1:0]            den_next;
    wsp_side_t                   side_next;

    // setup stage: magnitudes and sign flags
    always_comb
    begin
        side_next.cw    = clip[3];
        side_next.w_neg = clip[3][COORD_W-1];
        side_next.vis   = !clip[3][COORD_W-1];
        side_next.dz    = (clip[3] == '0);
        den_next = clip[3][COORD_W-1] ? DEN_W'(0 - clip[3]) : clip[3];
        for (int l = 0; l < N_LANES; l++)
        begin
            side_next.n_neg[l]  = clip[l][COORD_W-1];
            side_next.n_zero[l] = (clip[l] == '0);
        end
    end

    for (genvar l = 0; l < N_LANES; l++)
    begin : g_setup
        assign num_next[0][l] = clip[l][COORD_W-1] ? {COORD_W'(0 - clip[l]), FRAC_W'(0)}
                                                   : {clip[l], FRAC_W'(0)};
        assign rem_next[0][l] = '0;
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_step
        for (genvar l = 0; l < N_LANES; l++)
        begin : g_lane
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           ge;
            assign trial = {rem_reg[i][l], num_reg[i][l][NUM_W-1]};
            assign diff  = trial - {1'b0, den_reg[i]};
            assign ge    = (trial >= {1'b0, den_reg[i]});
            assign rem_next[i+1][l] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            assign num_next[i+1][l] = {num_reg[i][l][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        den_reg[0]  <= den_next;
        side_reg[0] <= side_next;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            den_reg[i+1]  <= den_reg[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[DIV_STEPS];
    assign side      = side_reg[DIV_STEPS];
    for (genvar l = 0; l < N_LANES; l++)
    begin : g_out
        assign quot[l] = num_reg[DIV_STEPS][l];
    end

endmodule

/* rtl/core/wsp_viewport.sv */
// ----------------------------------------------------------------------------
// wsp_viewport
// Quotient signs and zero-w saturation, viewport scale, offset and clamp.
// ----------------------------------------------------------------------------
module wsp_viewport
    import wsp_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [N_LANES-1:0][NUM_W-1:0]      quot,
    input  wsp_side_t                          side,
    output logic                               done,
    output logic                               visible,
    output logic                               div_by_zero,
    output logic signed [COORD_W-1:0]          screen_x,
    output logic signed [COORD_W-1:0]          screen_y,
    output logic signed [COORD_W-1:0]          depth,
    output logic signed [COORD_W-1:0]          clip_w
);

    logic                        v1_reg;
    logic                        v2_reg;
    logic                        done_reg;
    logic signed [NUM_W:0]       q_reg [N_LANES];
    logic signed [NUM_W:0]       q_next [N_LANES];
    wsp_side_t                   side1_reg;
    wsp_side_t                   side2_reg;
    logic signed [63:0]          px_reg;
    logic signed [63:0]          py_reg;
    logic signed [63:0]          qz_reg;
    logic                        vis_reg;
    logic                        dz_reg;
    logic [COORD_W-1:0]          sx_reg;
    logic [COORD_W-1:0]          sy_reg;
    logic [COORD_W-1:0]          dp_reg;
    logic [COORD_W-1:0]          cw_reg;

    always_comb
    begin
        for (int l = 0; l < N_LANES; l++)
        begin
            if (side.dz)
            begin
                if (side.n_zero[l])
                begin
                    q_next[l] = '0;
                end
                else if (side.n_neg[l])
                begin
                    q_next[l] = (NUM_W+1)'(SAT_MIN);
                end
                else
                begin
                    q_next[l] = (NUM_W+1)'(SAT_MAX);
                end
            end
            else if (side.n_neg[l] ^ side.w_neg)
            begin
                q_next[l] = -$signed({1'b0, quot[l]});
            end
            else
            begin
                q_next[l] = $signed({1'b0, quot[l]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        side1_reg <= side;
        px_reg    <= 64'(q_reg[0]) * HALF_W;
        py_reg    <= 64'(q_reg[1]) * NEG_HALF_H;
        qz_reg    <= 64'(q_reg[2]);
        side2_reg <= side1_reg;
        vis_reg   <= side2_reg.vis;
        dz_reg    <= side2_reg.dz;
        cw_reg    <= side2_reg.cw;
        // hidden points report zero screen fields
        sx_reg    <= side2_reg.vis ? sat32(px_reg + SX_OFFSET) : '0;
        sy_reg    <= side2_reg.vis ? sat32(py_reg + SY_OFFSET) : '0;
        dp_reg    <= side2_reg.vis ? sat32(qz_reg) : '0;
    end

    assign done        = done_reg;
    assign visible     = vis_reg;
    assign div_by_zero = dz_reg;
    assign screen_x    = sx_reg;
    assign screen_y    = sy_reg;
    assign depth       = dp_reg;
    assign clip_w      = cw_reg;

endmodule

/* rtl/core/world_to_screen_projection_unit.sv */
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// Projects a Q16.16 world point through a 4x4 matrix onto an 800x600 screen.
// ----------------------------------------------------------------------------
// A point is taken on every cycle with start high (busy never rises) and its
// word appears with done high after the input, product and clip-sum
// registers, the bit-per-stage divider that forms the 48-bit quotients and
// the viewport scaling and clamping registers. The receiver cannot stall;
// each word is valid for one cycle only. Matrix words are written through
// cfg_we/cfg_addr/cfg_wdata; the user must write them only while no point is
// in flight, unchecked by the block; indexes 8 and above are ignored.
module world_to_screen_projection_unit
    import wsp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [COORD_W-1:0]   pos_x,
    input  logic signed [COORD_W-1:0]   pos_y,
    input  logic signed [COORD_W-1:0]   pos_z,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [PAIR_W-1:0]           cfg_wdata,
    output logic                        done,
    output logic                        visible,
    output logic                        div_by_zero,
    output logic signed [COORD_W-1:0]   screen_x,
    output logic signed [COORD_W-1:0]   screen_y,
    output logic signed [COORD_W-1:0]   depth,
    output logic signed [COORD_W-1:0]   clip_w
);

    logic [N_PAIRS-1:0][PAIR_W-1:0]   m_pair_reg;
    logic                             xf_valid;
    logic [3:0][COORD_W-1:0]          clip;
    logic                             dv_valid;
    logic [N_LANES-1:0][NUM_W-1:0]    quot;
    wsp_side_t                        side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_pair_reg <= M_RESET;
        end
        else if (cfg_we && !cfg_addr[CFG_IDX_W-1])
        begin
            m_pair_reg[cfg_addr[CFG_IDX_W-2:0]] <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    wsp_transform u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .m_pair    (m_pair_reg),
        .out_valid (xf_valid),
        .clip      (clip)
    );

    wsp_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xf_valid),
        .clip      (clip),
        .out_valid (dv_valid),
        .quot      (quot),
        .side      (side)
    );

    wsp_viewport u_viewport (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (dv_valid),
        .quot        (quot),
        .side        (side),
        .done        (done),
        .visible     (visible),
        .div_by_zero (div_by_zero),
        .screen_x    (screen_x),
        .screen_y    (screen_y),
        .depth       (depth),
        .clip_w      (clip_w)
    );

endmodule

/* verif/wsp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsp_checker
// Watches the point, result and matrix-write ports of the projection unit,
// predicts every result word from its own copy of the matrix and compares
// each returned word field by field, in order.
// ----------------------------------------------------------------------------
module wsp_checker
    import wsp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [COORD_W-1:0]   pos_x,
    input  logic signed [COORD_W-1:0]   pos_y,
    input  logic signed [COORD_W-1:0]   pos_z,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [PAIR_W-1:0]           cfg_wdata,
    input  logic                        done,
    input  logic                        visible,
    input  logic                        div_by_zero,
    input  logic signed [COORD_W-1:0]   screen_x,
    input  logic signed [COORD_W-1:0]   screen_y,
    input  logic signed [COORD_W-1:0]   depth,
    input  logic signed [COORD_W-1:0]   clip_w,
    output int                          err_count,
    output int                          pending,
    output int                          n_words,
    output int                          n_hidden,
    output int                          n_dz
);

    typedef struct packed {
        logic               vis;
        logic               dz;
        logic [31:0]        sx;
        logic [31:0]        sy;
        logic [31:0]        dp;
        logic [31:0]        cw;
    } screen_word_t;

    logic [PAIR_W-1:0] mat_words [N_PAIRS];
    screen_word_t      expected_words [$];

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v);
        if (v > SAT_MAX)
        begin
            return SAT_MAX;
        end
        if (v < SAT_MIN)
        begin
            return SAT_MIN;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] mat_entry(input int k);
        logic signed [31:0] h;
        h = k[0] ? mat_words[k >> 1][63:32] : mat_words[k >> 1][31:0];
        return 64'(h);
    endfunction

    // row r of the matrix times (x, y, z, 1), products floored to Q16.16
    function automatic logic signed [63:0] clip_row(input int r,
        input logic signed [63:0] x, input logic signed [63:0] y,
        input logic signed [63:0] z);
        logic signed [63:0] s;
        s = ((x * mat_entry(r)) >>> 16) + ((y * mat_entry(4 + r)) >>> 16)
          + ((z * mat_entry(8 + r)) >>> 16) + mat_entry(12 + r);
        return sat64(s);
    endfunction

    function automatic logic signed [63:0] divide_by_w(input logic signed [63:0] n,
        input logic signed [63:0] w);
        if (w == 0)
        begin
            return (n > 0) ? SAT_MAX : ((n < 0) ? SAT_MIN : 64'sd0);
        end
        return (n * 64'sd65536) / w;
    endfunction

    function automatic screen_word_t project_point(input logic signed [31:0] px,
        input logic signed [31:0] py, input logic signed [31:0] pz);
        screen_word_t       o;
        logic signed [63:0] x, y, z, cx, cy, cz, cw, qx, qy, qz;
        x = px;
        y = py;
        z = pz;
        cx = clip_row(0, x, y, z);
        cy = clip_row(1, x, y, z);
        cz = clip_row(2, x, y, z);
        cw = clip_row(3, x, y, z);
        o = '0;
        o.vis = (cw >= 0);
        o.dz = (cw == 0);
        o.cw = cw[31:0];
        if (o.vis)
        begin
            qx = divide_by_w(cx, cw);
            qy = divide_by_w(cy, cw);
            qz = divide_by_w(cz, cw);
            o.sx = 32'(sat64(qx * 64'sd400 + 64'sd26214400));
            o.sy = 32'(sat64(qy * -64'sd300 + 64'sd19660800));
            o.dp = 32'(sat64(qz));
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_word_t e, a;
        if (!rst_n)
        begin
            for (int i = 0; i < N_PAIRS; i++)
            begin
                mat_words[i] <= M_RESET[i];
            end
            expected_words.delete();
            err_count <= 0;
            pending <= 0;
            n_words <= 0;
            n_hidden <= 0;
            n_dz <= 0;
        end
        else
        begin
            if (cfg_we && cfg_addr < N_PAIRS)
            begin
                mat_words[cfg_addr[CFG_IDX_W-2:0]] <= cfg_wdata;
            end
            if (start && !busy)
            begin
                expected_words.push_back(project_point(pos_x, pos_y, pos_z));
            end
            if (done)
            begin
                a = {visible, div_by_zero, screen_x, screen_y, depth, clip_w};
                n_words <= n_words + 1;
                n_hidden <= n_hidden + (visible ? 0 : 1);
                n_dz <= n_dz + (div_by_zero ? 1 : 0);
                if (expected_words.size() == 0)
                begin
                    if (err_count < 10)
                    begin
                        $display("%0t: result word with nothing expected", $realtime);
                    end
                    err_count <= err_count + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (a !== e)
                    begin
                        if (err_count < 10)
                        begin
                            $display("%0t: mismatch vis %b/%b dz %b/%b sx %h/%h sy %h/%h",
                                $realtime, e.vis, a.vis, e.dz, a.dz, e.sx, a.sx,
                                e.sy, a.sy);
                            $display("    depth %h/%h clip_w %h/%h (expected/actual)",
                                e.dp, a.dp, e.cw, a.cw);
                        end
                        err_count <= err_count + 1;
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives points and matrix writes into the projection unit: directed corner
// points under identity, perspective and zero matrices, then random phases
// with random, perspective, identity and extreme matrices. A checker module
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench
    import wsp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [PAIR_W-1:0] cfg_wdata = '0;
    logic busy, done, visible, div_by_zero;
    logic signed [COORD_W-1:0] screen_x, screen_y, depth, clip_w;
    int err_count, pending, n_words, n_hidden, n_dz;
    int n_points = 0;
    int stall_cycles = 0;
    bit idle_en = 1'b1;
    logic [31:0] matrix [16];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    world_to_screen_projection_unit dut (.*);

    wsp_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_we)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[world_to_screen_projection_unit] ERROR");
            $finish;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
        input logic [31:0] z);
        if (idle_en && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        n_points++;
    endtask

    // let every word come back, then the block is idle for matrix writes
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_matrix();
        for (int i = 0; i < N_PAIRS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= CFG_IDX_W'(i);
            cfg_wdata <= {matrix[2 * i + 1], matrix[2 * i]};
            @(posedge clk);
        end
        // out-of-range index must be dropped
        cfg_addr <= CFG_IDX_W'($urandom_range(N_PAIRS, 15));
        cfg_wdata <= {$urandom, $urandom};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(524288) - 262144;
            2: return 32'h0;
            default: return $urandom_range(1) ? ONE : NEG_ONE;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(2) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(8388608) - 4194304;
    endfunction

    task automatic set_identity();
        for (int k = 0; k < 16; k++)
        begin
            matrix[k] = (k % 5 == 0) ? ONE : 32'h0;
        end
    endtask

    // w = -z, camera looking down minus z
    task automatic set_perspective();
        set_identity();
        matrix[11] = NEG_ONE;
        matrix[15] = 32'h0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrix is identity, w = 1.0
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_point(ONE, NEG_ONE, 32'h0000_8000);
        drain();

        set_perspective();
        write_matrix();
        send_point(ONE, ONE, 32'hFFFE_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_point(ONE, NEG_ONE, 32'h0);
        send_point(NEG_ONE, ONE, 32'h0);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(ONE, ONE, ONE);
        send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        for (int k = 0; k < 16; k++)
        begin
            matrix[k] = 32'h0;
        end
        write_matrix();
        send_point(32'h7FFF_FFFF, 32'h8000_0000, ONE);
        send_point($urandom, $urandom, $urandom);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:
                begin
                    for (int k = 0; k < 16; k++)
                    begin
                        matrix[k] = rand_entry();
                    end
                end
                1:
                begin
                    set_perspective();
                    for (int k = 0; k < 4; k++)
                    begin
                        matrix[$urandom_range(14)] = rand_entry();
                    end
                end
                2: set_identity();
                default:
                begin
                    for (int k = 0; k < 16; k++)
                    begin
                        matrix[k] = ((k + p) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    end
                end
            endcase
            write_matrix();
            idle_en = (p != 2);
            for (int i = 0; i < 172; i++)
            begin
                send_point(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        $display("%0d points sent, %0d words checked, %0d behind the camera, %0d with w = 0",
            n_points, n_words, n_hidden, n_dz);
        $display("matrices: identity, perspective, zero, random and saturating extremes");
        if (err_count == 0)
        begin
            $display("[world_to_screen_projection_unit] OK");
        end
        else
        begin
            $display("[world_to_screen_projection_unit] ERROR");
        end
        $finish;
    end

endmodule
